FILE: hw/rtl/mbfe_pkg.sv
// ----------------------------------------------------------------------------
// mbfe_pkg
// Shared types, constants and code tables for the Morse BPSK frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfe_pkg;

   localparam int SYM_W         = 22;
   localparam int LEN_W         = 5;
   localparam int CNT_W         = 8;
   localparam int CHECKSUM_BITS = 8;
   localparam int STR_CHARS     = 19;
   localparam int GAP_UNITS     = 3;
   localparam int QUEUE_DEPTH   = 2;
   localparam int REQ_W         = 16;
   localparam int RSP_W         = 8;

   typedef enum logic [1:0] {
      ACT_BEGIN = 2'd0,
      ACT_CHAR  = 2'd1,
      ACT_END   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PRE,
      BK_SYM,
      BK_HOLD
   } back_state_type;

   // marks[len-1] is the first unit, marks[0] the last; a set bit is a mark
   typedef struct packed {
      logic             pre;
      logic             hold;
      logic [LEN_W-1:0] len;
      logic [SYM_W-1:0] marks;
   } desc_type;

   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] len;
      logic [SYM_W-1:0] marks;
   } code_type;

   localparam logic [SYM_W-1:0] PREAMBLE_MARKS = SYM_W'(4'b0010);
   localparam logic [LEN_W-1:0] PREAMBLE_LEN   = LEN_W'(4);

   function automatic logic [8*STR_CHARS-1:0] letter_str(input logic [4:0] idx);
      logic [8*STR_CHARS-1:0] s;
      unique case (idx)
         5'd0:  s = "*_***";
         5'd1:  s = "***_*_*_*";
         5'd2:  s = "***_*_***_*";
         5'd3:  s = "***_*_*";
         5'd4:  s = "*";
         5'd5:  s = "*_*_***_*";
         5'd6:  s = "***_***_*";
         5'd7:  s = "*_*_*_*";
         5'd8:  s = "*_*";
         5'd9:  s = "*_***_***_***";
         5'd10: s = "***_*_***";
         5'd11: s = "*_***_*_*";
         5'd12: s = "***_***";
         5'd13: s = "***_*";
         5'd14: s = "***_***_***";
         5'd15: s = "*_***_***_*";
         5'd16: s = "***_***_*_***";
         5'd17: s = "*_***_*";
         5'd18: s = "*_*_*";
         5'd19: s = "***";
         5'd20: s = "*_*_***";
         5'd21: s = "*_*_*_***";
         5'd22: s = "*_***_***";
         5'd23: s = "***_*_*_***";
         5'd24: s = "***_*_***_***";
         5'd25: s = "***_***_*_*";
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [8*STR_CHARS-1:0] digit_str(input logic [3:0] idx);
      logic [8*STR_CHARS-1:0] s;
      unique case (idx)
         4'd0: s = "***_***_***_***_***";
         4'd1: s = "*_***_***_***_***";
         4'd2: s = "*_*_***_***_***";
         4'd3: s = "*_*_*_***_***";
         4'd4: s = "*_*_*_*_***";
         4'd5: s = "*_*_*_*_*";
         4'd6: s = "***_*_*_*_*";
         4'd7: s = "***_***_*_*_*";
         4'd8: s = "***_***_***_*_*";
         4'd9: s = "***_***_***_***_*";
         default: s = '0;
      endcase
      return s;
   endfunction

   // pack a unit string and append the letter gap
   function automatic code_type pack_str(input logic [8*STR_CHARS-1:0] s);
      code_type   c;
      logic [7:0] ch;
      c = '0;
      for (int j = STR_CHARS - 1; j >= 0; j--) begin
         ch = s[8*j +: 8];
         if (ch != 8'h00) begin
            c.marks = {c.marks[SYM_W-2:0], ch == "*"};
            c.len   = c.len + 1'b1;
         end
      end
      c.marks = c.marks << GAP_UNITS;
      c.len   = c.len + LEN_W'(GAP_UNITS);
      c.valid = 1'b1;
      return c;
   endfunction

   function automatic code_type char_code(input logic [7:0] ch);
      code_type   c;
      logic [7:0] off;
      c = '0;
      if (ch >= "a" && ch <= "z") begin
         off = ch - 8'h61;
         c   = pack_str(letter_str(off[4:0]));
      end else if (ch >= "A" && ch <= "Z") begin
         off = ch - 8'h41;
         c   = pack_str(letter_str(off[4:0]));
      end else if (ch >= "0" && ch <= "9") begin
         off = ch - 8'h30;
         c   = pack_str(digit_str(off[3:0]));
      end else if (ch == " ") begin
         off = '0;
         c   = pack_str("____");
      end else begin
         off = '0;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mbfe_front.sv
// ----------------------------------------------------------------------------
// mbfe_front
// Accept frame actions, track frame and mark count, queue unit descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfe_front
   import mbfe_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [1:0]     req_action,
   input  wire logic [7:0]     req_char_code,
   input  wire logic           q_full,
   output logic                q_push,
   output desc_type            q_desc
);

   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] mark_count_ff, mark_count_in;
   logic             accept;
   code_type         code;
   logic [SYM_W-1:0] sum_marks;
   action_type       act;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign act        = action_type'(req_action);
   assign code       = char_code(req_char_code);

   always_comb begin
      sum_marks = '0;
      for (int i = 0; i < CHECKSUM_BITS; i++) begin
         if (i < CNT_W) begin
            sum_marks[CHECKSUM_BITS-1-i] = !mark_count_ff[i];
         end else begin
            sum_marks[CHECKSUM_BITS-1-i] = 1'b1;
         end
      end
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      mark_count_in = mark_count_ff;
      q_push        = 1'b0;
      q_desc        = '0;
      if (accept) begin
         unique case (act)
            ACT_BEGIN: begin
               q_push        = 1'b1;
               q_desc.pre    = 1'b1;
               q_desc.len    = PREAMBLE_LEN;
               q_desc.marks  = PREAMBLE_MARKS;
               mark_count_in = CNT_W'(1);
               in_frame_in   = 1'b1;
            end
            ACT_CHAR: begin
               if (in_frame_ff && code.valid) begin
                  q_push        = 1'b1;
                  q_desc.len    = code.len;
                  q_desc.marks  = code.marks;
                  mark_count_in = mark_count_ff + CNT_W'($countones(code.marks));
               end
            end
            ACT_END: begin
               if (in_frame_ff) begin
                  q_push       = 1'b1;
                  q_desc.hold  = 1'b1;
                  q_desc.len   = LEN_W'(CHECKSUM_BITS);
                  q_desc.marks = sum_marks;
                  in_frame_in  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         mark_count_ff <= CNT_W'(1);
      end else begin
         in_frame_ff   <= in_frame_in;
         mark_count_ff <= mark_count_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mbfe_queue.sv
// ----------------------------------------------------------------------------
// mbfe_queue
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfe_queue
   import mbfe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_desc,
   output logic          full,
   input  wire logic     pop,
   output logic          head_valid,
   output desc_type      head_desc
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   desc_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full       = fill_ff == FILL_W'(QUEUE_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mbfe_back.sv
// ----------------------------------------------------------------------------
// mbfe_back
// Unit sequencer: differential phase, Manchester halves, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfe_back
   import mbfe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire desc_type q_desc,
   output logic          q_pop,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   output logic          rsp_first_half,
   output logic          rsp_second_half,
   output logic          rsp_last
);

   back_state_type   state_ff, state_in;
   logic             phase_ff, phase_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic             hold_ff, hold_in;
   logic [SYM_W-1:0] marks_ff, marks_in;
   logic             valid_ff;
   logic             first_ff, second_ff, last_ff;
   logic             out_free;
   logic             emit, u_first, u_second, u_last;
   logic [LEN_W-1:0] sym_idx;
   logic             ph;

   assign out_free = !valid_ff || rsp_tready;
   assign sym_idx  = cnt_ff - 1'b1;
   assign ph       = phase_ff ^ marks_ff[sym_idx];

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      hold_in  = hold_ff;
      marks_in = marks_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      u_first  = 1'b0;
      u_second = 1'b0;
      u_last   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cnt_in   = q_desc.len;
               hold_in  = q_desc.hold;
               marks_in = q_desc.marks;
               state_in = q_desc.pre ? BK_PRE : BK_SYM;
            end
         end
         BK_PRE: begin
            if (out_free) begin
               emit     = 1'b1;
               phase_in = 1'b0;
               state_in = BK_SYM;
            end
         end
         BK_SYM: begin
            if (out_free) begin
               emit     = 1'b1;
               u_first  = ph;
               u_second = !ph;
               phase_in = ph;
               cnt_in   = cnt_ff - 1'b1;
               if (cnt_ff == LEN_W'(1)) begin
                  u_last   = !hold_ff;
                  state_in = hold_ff ? BK_HOLD : BK_IDLE;
               end
            end
         end
         BK_HOLD: begin
            if (out_free) begin
               emit     = 1'b1;
               u_first  = !phase_ff;
               u_second = !phase_ff;
               u_last   = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      hold_ff  <= hold_in;
      marks_ff <= marks_in;
      if (emit) begin
         first_ff  <= u_first;
         second_ff <= u_second;
         last_ff   <= u_last;
      end
   end

   assign rsp_tvalid      = valid_ff;
   assign rsp_first_half  = first_ff;
   assign rsp_second_half = second_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/morse_bpsk_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// morse_bpsk_frame_encoder_top
// Morse frame encoder with differential BPSK and Manchester unit halves.
// ----------------------------------------------------------------------------
// Each request is a frame action (begin, character, end) and yields a run of
// units, one per response, tlast on the final unit; requests that yield no
// unit (unknown character, character or end outside a frame, action 3) are
// taken and dropped. The back sequencer emits one unit per cycle while the
// response is not stalled, and loads each descriptor in its idle state,
// which emits no unit; it takes no new descriptor before the last is out. A
// two-entry descriptor queue lets requests be taken while units stream out.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_bpsk_frame_encoder_top
   import mbfe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // action[1:0], char_code[9:2], zero
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // first_half[0], second_half[1],
                                              // enable_pin[2], zero
   output logic                  rsp_tlast
);

   logic     q_full, q_push, q_pop, q_valid;
   desc_type push_desc, head_desc;
   logic     first_half, second_half;

   mbfe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_action    (req_tdata[1:0]),
      .req_char_code (req_tdata[9:2]),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_desc        (push_desc)
   );

   mbfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (push_desc),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_desc  (head_desc)
   );

   mbfe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_desc          (head_desc),
      .q_pop           (q_pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_first_half  (first_half),
      .rsp_second_half (second_half),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_W - 3){1'b0}}, 1'b0, second_half, first_half};

endmodule

`default_nettype wire

FILE: hw/rtl/mbfe_checker.sv
// ----------------------------------------------------------------------------
// mbfe_checker
// Port-level checks on the encoder response stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfe_checker
   import mbfe_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic             rsp_tlast
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_enable_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2] == 1'b0 && rsp_tdata[RSP_W-1:3] == '0)
      else $error("enable or pad bits set in a unit");

   a_manchester: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && rsp_tdata[0] == rsp_tdata[1] |-> rsp_tdata[0] == 1'b0)
      else $error("flat unit other than the idle or hold unit");

endmodule

bind morse_bpsk_frame_encoder_top mbfe_checker u_mbfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
